// ===== sv/mfbs_pkg.sv =====
package mfbs_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;

  localparam logic [BYTE_W-1:0] PREFIX_LAST  = 8'h01;
  localparam logic [BYTE_W-1:0] SLICE_LAST   = 8'hAF;
  localparam logic [BYTE_W-1:0] SEQ_END_CODE = 8'hB7;
  localparam logic [1:0]        PREFIX_ZEROS = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEFORE_CODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_AFTER_BYTE  = 2'd2;

  typedef struct packed {
    logic              code_seen;
    logic [BYTE_W-1:0] code_value;
    logic              slice_layer;
    logic [KIND_W-1:0] boundary_kind;
  } mfbs_result_t;

endpackage

// ===== sv/mfbs_scan_core.sv =====
module mfbs_scan_core
  import mfbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              new_search,
  output mfbs_result_t      result
);

  logic       seeking_zero_r, seeking_zero_nxt;
  logic [1:0] zero_run_r, zero_run_nxt;
  logic       code_pending_r, code_pending_nxt;
  logic       in_slice_r, in_slice_nxt;
  logic       search_done_r, search_done_nxt;

  always_comb begin
    logic is_zero;
    logic is_slice;
    is_zero  = (data_byte == '0);
    is_slice = !is_zero && (data_byte <= SLICE_LAST);

    // Clear before the byte is scanned when a new search starts.
    if (new_search) begin
      seeking_zero_nxt = 1'b1;
      zero_run_nxt     = 2'd0;
      code_pending_nxt = 1'b0;
      in_slice_nxt     = 1'b0;
      search_done_nxt  = 1'b0;
    end else begin
      seeking_zero_nxt = seeking_zero_r;
      zero_run_nxt     = zero_run_r;
      code_pending_nxt = code_pending_r;
      in_slice_nxt     = in_slice_r;
      search_done_nxt  = search_done_r;
    end

    result.code_seen     = 1'b0;
    result.code_value    = '0;
    result.boundary_kind = KIND_NONE;

    if (!search_done_nxt) begin
      if (code_pending_nxt) begin
        code_pending_nxt  = 1'b0;
        result.code_seen  = 1'b1;
        result.code_value = data_byte;
        if (in_slice_nxt) begin
          if (!is_slice) begin
            result.boundary_kind = (data_byte == SEQ_END_CODE) ? KIND_AFTER_BYTE
                                                               : KIND_BEFORE_CODE;
            search_done_nxt = 1'b1;
          end
        end else if (is_slice) begin
          in_slice_nxt = 1'b1;
        end
      end

      // Prefix detector; the code byte feeds it too.
      if (!search_done_nxt) begin
        if (seeking_zero_nxt) begin
          if (is_zero) begin
            seeking_zero_nxt = 1'b0;
            zero_run_nxt     = 2'd1;
          end
        end else if (is_zero) begin
          if (zero_run_nxt < PREFIX_ZEROS) begin
            zero_run_nxt = zero_run_nxt + 2'd1;
          end
        end else begin
          seeking_zero_nxt = 1'b1;
          if (zero_run_nxt >= PREFIX_ZEROS && data_byte == PREFIX_LAST) begin
            code_pending_nxt = 1'b1;
          end
          zero_run_nxt = 2'd0;
        end
      end
    end

    result.slice_layer = in_slice_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeking_zero_r <= 1'b1;
      zero_run_r     <= 2'd0;
      code_pending_r <= 1'b0;
      in_slice_r     <= 1'b0;
      search_done_r  <= 1'b0;
    end else if (adv) begin
      seeking_zero_r <= seeking_zero_nxt;
      zero_run_r     <= zero_run_nxt;
      code_pending_r <= code_pending_nxt;
      in_slice_r     <= in_slice_nxt;
      search_done_r  <= search_done_nxt;
    end
  end

endmodule

// ===== sv/mpeg1_frame_boundary_scanner.sv =====
// MPEG-1 frame boundary scanner. Feed the video stream one byte per item;
// each item yields exactly one result item. A start code is two or more
// zero bytes, then 0x01, then the code value byte; code_seen flags that
// value byte. After a slice code (0x01..0xAF) the first non-slice code
// ends the frame: boundary_kind 2 for a sequence end code (frame ends
// after this byte), 1 for any other code (frame ends before its 4-byte
// start code). After a boundary every byte is ignored until an item with
// new_search set, which clears the scanner before its byte is scanned.
// Throughput is one item per cycle while the result channel takes its results.
// An item passes the input register, then the result register, where its
// result is valid until taken. Back-pressure on the result channel stalls
// the input only when both registers are full.
module mpeg1_frame_boundary_scanner
  import mfbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_new_search,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_code_seen,
  output logic [BYTE_W-1:0] out_code_value,
  output logic              out_slice_layer,
  output logic [KIND_W-1:0] out_boundary_kind
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] data_byte_r;
  logic              new_search_r;
  logic              out_valid_r;
  mfbs_result_t      res_r;
  mfbs_result_t      res_nxt;
  logic              adv;

  // Advance the held item into the result register when that slot frees.
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Hold the payload while the item waits.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_byte_r  <= in_data_byte;
      new_search_r <= in_new_search;
    end
  end

  mfbs_scan_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .data_byte  (data_byte_r),
    .new_search (new_search_r),
    .result     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_seen     = res_r.code_seen;
  assign out_code_value    = res_r.code_value;
  assign out_slice_layer   = res_r.slice_layer;
  assign out_boundary_kind = res_r.boundary_kind;

endmodule

// ===== sv/mfbs_checker.sv =====
module mfbs_checker
  import mfbs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [BYTE_W-1:0] in_data_byte,
  input logic              in_new_search,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_code_seen,
  input logic [BYTE_W-1:0] out_code_value,
  input logic              out_slice_layer,
  input logic [KIND_W-1:0] out_boundary_kind
);

  // A boundary is only reported on a code byte found in the slice layer.
  a_boundary_on_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_boundary_kind != KIND_NONE |-> out_code_seen && out_slice_layer)
    else $error("boundary without slice-layer code");

  // Without a code byte the value and kind read as zero.
  a_quiet_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_code_seen |-> out_code_value == '0 && out_boundary_kind == KIND_NONE)
    else $error("stray code value or kind");

  // Kind 2 only for the sequence end code, kind 1 never for it.
  a_kind_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_seen && out_slice_layer && out_boundary_kind != KIND_NONE
    |-> (out_boundary_kind == KIND_AFTER_BYTE) == (out_code_value == SEQ_END_CODE))
    else $error("boundary kind does not match code");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_value)
      && $stable(out_boundary_kind) && $stable(out_slice_layer) && $stable(out_code_seen))
    else $error("result changed while stalled");

  // An input item waiting for ready holds its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) && $stable(in_new_search))
    else $error("input item changed while waiting");

endmodule

bind mpeg1_frame_boundary_scanner mfbs_checker u_mfbs_checker (.*);
